>>> rtl/core/atstk_pkg.sv
package atstk_pkg;

    // sizes
    localparam int STACK_DEPTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int WORD_W      = 32;
    localparam int OP_W        = 3;
    localparam int LEVEL_W     = 6;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ENTRY_WORDS = 12;
    localparam int MEM_DEPTH   = STACK_DEPTH * ENTRY_WORDS;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    // multiply-accumulate widths
    localparam int OPND_W = WORD_W + 1;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = PROD_W - FRAC_BITS + 3;

    // divider widths
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    // rotation widths
    localparam int Q30_SHIFT  = 30 - FRAC_BITS;
    localparam int ZM_W       = WORD_W + Q30_SHIFT;
    localparam int RED_STEPS  = ZM_W - 32;
    localparam int CORD_W     = 34;
    localparam int CORD_ITER  = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [WORD_W-1:0] Q_ONE   = WORD_W'(64'sd1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0]  ACC_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0]  ACC_MIN = -ACC_MAX - ACC_W'(1);

    localparam logic signed [CORD_W-1:0] Q30_PI      = CORD_W'(64'sd3373259426);
    localparam logic signed [CORD_W-1:0] Q30_HALF_PI = CORD_W'(64'sd1686629713);
    localparam logic signed [CORD_W-1:0] Q30_TWO_PI  = CORD_W'(64'sd6746518852);
    localparam logic signed [CORD_W-1:0] Q30_GAIN    = CORD_W'(64'sd652032874);
    localparam logic [ZM_W-1:0] RED_BASE = ZM_W'(64'd6746518852);
    localparam logic [ZM_W-1:0] RED_TOP  = RED_BASE << (RED_STEPS - 1);

    // command codes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_TRANS = 3'd2;
    localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
    localparam logic [OP_W-1:0] OP_ROT   = 3'd4;
    localparam logic [OP_W-1:0] OP_W2S   = 3'd5;
    localparam logic [OP_W-1:0] OP_S2W   = 3'd6;

    typedef enum logic [1:0] {
        JOB_PRE, JOB_DET, JOB_OFF, JOB_MAP
    } job_t;

    typedef enum logic [1:0] {
        DOT_NONE, DOT_MUL0, DOT_MUL1, DOT_FIN
    } dot_ph_t;

    typedef struct packed {
        logic             capture;
        logic             set_ign;
        logic             set_sing;
        logic             cnt_inc;
        logic             cnt_dec;
        logic             push_wr;
        logic             pop_rd;
        logic             load_l;
        logic             rot_start;
        logic             copy_d;
        logic             copy_v;
        logic             div_start;
        logic             div_wr;
        logic             load_out;
        dot_ph_t          dot_ph;
        job_t             job;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic rot_busy;
        logic div_busy;
        logic det_zero;
    } sts_t;

    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [WORD_W-1:0] r;
        if (v > ACC_MAX) begin
            r = ACC_MAX[WORD_W-1:0];
        end else if (v < ACC_MIN) begin
            r = ACC_MIN[WORD_W-1:0];
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    // arctangent of 2^-i in q30
    function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd843314857;
            5'd1:  r = 32'd497837829;
            5'd2:  r = 32'd263043837;
            5'd3:  r = 32'd133525159;
            5'd4:  r = 32'd67021687;
            5'd5:  r = 32'd33543516;
            5'd6:  r = 32'd16775851;
            5'd7:  r = 32'd8388437;
            5'd8:  r = 32'd4194283;
            5'd9:  r = 32'd2097149;
            5'd10: r = 32'd1048576;
            5'd11: r = 32'd524288;
            5'd12: r = 32'd262144;
            5'd13: r = 32'd131072;
            5'd14: r = 32'd65536;
            5'd15: r = 32'd32768;
            5'd16: r = 32'd16384;
            5'd17: r = 32'd8192;
            5'd18: r = 32'd4096;
            5'd19: r = 32'd2048;
            5'd20: r = 32'd1024;
            5'd21: r = 32'd512;
            5'd22: r = 32'd256;
            5'd23: r = 32'd128;
            5'd24: r = 32'd64;
            5'd25: r = 32'd32;
            5'd26: r = 32'd16;
            5'd27: r = 32'd8;
            5'd28: r = 32'd4;
            5'd29: r = 32'd2;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/affine_transform_stack.sv
// the four serial divides by the determinant dominate translate, scale and rotate
// throughput: one command at a time, the next is taken once the result is in
// the output register; a waiting result does not block accepting the next
// command, but that command's result is held back until the output is taken
// reset: synchronous active-low aresetn restores identity matrices, empty stack,
// idle controller and no pending result; stack memory is not cleared
module affine_transform_stack import atstk_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, scale_factor, angle
    input  logic [2:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // result_x, result_y, stack_level, zero pad
    output logic [1:0]   m_tuser    // singular, ignored
);

    cmd_t cmd;
    sts_t sts;
    logic signed [WORD_W-1:0] res_x, res_y;
    logic [LEVEL_W-1:0]       res_level;
    logic                     res_sing, res_ign;

    atstk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atstk_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_tuser),
        .in_x      (s_tdata[31:0]),
        .in_y      (s_tdata[63:32]),
        .in_sc     (s_tdata[95:64]),
        .in_ang    (s_tdata[127:96]),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_level (res_level),
        .res_sing  (res_sing),
        .res_ign   (res_ign)
    );

    // result beat packing
    assign m_tdata = {2'b00, res_level, res_y, res_x};
    assign m_tuser = {res_ign, res_sing};

endmodule

>>> rtl/core/atstk_dp.sv
module atstk_dp import atstk_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [OP_W-1:0]          in_op,
    input  logic signed [WORD_W-1:0] in_x,
    input  logic signed [WORD_W-1:0] in_y,
    input  logic signed [WORD_W-1:0] in_sc,
    input  logic signed [WORD_W-1:0] in_ang,
    output logic signed [WORD_W-1:0] res_x,
    output logic signed [WORD_W-1:0] res_y,
    output logic [LEVEL_W-1:0]       res_level,
    output logic                     res_sing,
    output logic                     res_ign
);

    typedef enum logic [2:0] {
        RP_RED  = 3'b001,
        RP_FOLD = 3'b010,
        RP_ITER = 3'b100
    } rot_ph_t;

    localparam logic [NUM_W-1:0] Q_POS_LIM = NUM_W'(64'd2147483647);
    localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(64'd2147483648);

    // captured item
    logic [OP_W-1:0]          op_reg;
    logic signed [WORD_W-1:0] px_reg, py_reg, sc_reg, ang_reg;

    // matrices
    logic signed [WORD_W-1:0] fwd_reg [6];
    logic signed [WORD_W-1:0] inv_reg [6];
    logic signed [WORD_W-1:0] l_reg [6];
    logic signed [WORD_W-1:0] d_reg [6];
    logic signed [WORD_W-1:0] v_reg [6];
    logic signed [WORD_W-1:0] m_sel [6];

    logic [CNT_W-1:0] cnt_reg;
    logic             sing_reg, ign_reg;
    logic signed [WORD_W-1:0] rx_reg, ry_reg;
    logic signed [WORD_W-1:0] out_x_reg, out_y_reg;
    logic [LEVEL_W-1:0]       out_level_reg;
    logic                     out_sing_reg, out_ign_reg;

    // multiply-accumulate
    logic signed [OPND_W-1:0] a0, b0, a1, b1, mul_a, mul_b;
    logic signed [ACC_W-1:0]  c_term, prod_fl, fin_sum;
    logic                     neg_t1;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, det_reg;
    logic signed [WORD_W-1:0] fin_sat;

    // stack memory
    logic [WORD_W-1:0] mem [MEM_DEPTH];
    logic [WORD_W-1:0] mem_rd_reg;
    logic [WORD_W-1:0] push_word;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] mem_addr;
    logic              pop_wb_reg;
    logic [IDX_W-1:0]  pop_idx_reg;

    // divider
    logic                    div_busy_reg, div_neg_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic [NUM_W-1:0]        q_reg;
    logic [ACC_W-1:0]        rem_reg, den_reg;
    logic [ACC_W:0]          rem_sh;
    logic signed [WORD_W-1:0] div_t;
    logic [WORD_W-1:0]       div_tm;
    logic [ACC_W-1:0]        det_mag;
    logic signed [WORD_W-1:0] q_sat;

    // rotation
    logic                     rot_busy_reg, z_neg_reg, flip_reg;
    rot_ph_t                  rot_ph_reg;
    logic [ZM_W-1:0]          zm_reg, mod_reg;
    logic signed [CORD_W-1:0] x_reg, y_reg, z_reg;
    logic [ATAN_IDX_W-1:0]    it_reg;
    logic signed [WORD_W-1:0] cs_reg, sn_reg;
    logic signed [CORD_W-1:0] zs, z1, z2, xs, ys, nx, ny, nz, atan_v, fx, fy;
    logic                     flip_n;
    logic [WORD_W-1:0]        ang_mag;

    function automatic logic signed [WORD_W-1:0] q30_round(
        input logic signed [CORD_W-1:0] v
    );
        logic signed [CORD_W:0] t;
        t = {v[CORD_W-1], v} + ((CORD_W + 1)'(1) << (Q30_SHIFT - 1));
        return WORD_W'(t >>> Q30_SHIFT);
    endfunction

    function automatic logic signed [OPND_W-1:0] ext(input logic signed [WORD_W-1:0] v);
        return {v[WORD_W-1], v};
    endfunction

    function automatic logic signed [ACC_W-1:0] extacc(input logic signed [WORD_W-1:0] v);
        return ACC_W'(v);
    endfunction

    // matrix used for point mapping
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            m_sel[k] = (op_reg == OP_S2W) ? inv_reg[k] : fwd_reg[k];
        end
    end

    // dot-product operand select
    always_comb begin
        a0 = '0; b0 = '0; a1 = '0; b1 = '0; c_term = '0; neg_t1 = 1'b0;
        unique case (cmd.job)
            JOB_PRE: begin
                unique case (cmd.idx)
                    4'd0: begin
                        a0 = ext(l_reg[0]); b0 = ext(fwd_reg[0]);
                        a1 = ext(l_reg[1]); b1 = ext(fwd_reg[3]);
                    end
                    4'd1: begin
                        a0 = ext(l_reg[0]); b0 = ext(fwd_reg[1]);
                        a1 = ext(l_reg[1]); b1 = ext(fwd_reg[4]);
                    end
                    4'd2: begin
                        a0 = ext(l_reg[0]); b0 = ext(fwd_reg[2]);
                        a1 = ext(l_reg[1]); b1 = ext(fwd_reg[5]);
                        c_term = extacc(l_reg[2]);
                    end
                    4'd3: begin
                        a0 = ext(l_reg[3]); b0 = ext(fwd_reg[0]);
                        a1 = ext(l_reg[4]); b1 = ext(fwd_reg[3]);
                    end
                    4'd4: begin
                        a0 = ext(l_reg[3]); b0 = ext(fwd_reg[1]);
                        a1 = ext(l_reg[4]); b1 = ext(fwd_reg[4]);
                    end
                    4'd5: begin
                        a0 = ext(l_reg[3]); b0 = ext(fwd_reg[2]);
                        a1 = ext(l_reg[4]); b1 = ext(fwd_reg[5]);
                        c_term = extacc(l_reg[5]);
                    end
                    default: begin
                    end
                endcase
            end
            JOB_DET: begin
                a0 = ext(fwd_reg[0]); b0 = ext(fwd_reg[4]);
                a1 = ext(fwd_reg[1]); b1 = ext(fwd_reg[3]);
                neg_t1 = 1'b1;
            end
            JOB_OFF: begin
                b0 = -ext(fwd_reg[2]);
                b1 = -ext(fwd_reg[5]);
                if (cmd.idx == 4'd0) begin
                    a0 = ext(v_reg[0]); a1 = ext(v_reg[1]);
                end else begin
                    a0 = ext(v_reg[3]); a1 = ext(v_reg[4]);
                end
            end
            JOB_MAP: begin
                a0 = ext(px_reg); a1 = ext(py_reg);
                if (cmd.idx == 4'd0) begin
                    b0 = ext(m_sel[0]); b1 = ext(m_sel[1]); c_term = extacc(m_sel[2]);
                end else begin
                    b0 = ext(m_sel[3]); b1 = ext(m_sel[4]); c_term = extacc(m_sel[5]);
                end
            end
            default: begin
            end
        endcase
        mul_a = (cmd.dot_ph == DOT_MUL0) ? a0 : a1;
        mul_b = (cmd.dot_ph == DOT_MUL0) ? b0 : b1;
    end

    assign prod_fl = ACC_W'(prod_reg >>> FRAC_BITS);
    assign fin_sum = acc_reg + (neg_t1 ? -prod_fl : prod_fl);
    assign fin_sat = sat_word(fin_sum);

    // multiplier and accumulator
    always_ff @(posedge aclk) begin
        unique case (cmd.dot_ph)
            DOT_MUL0: begin
                prod_reg <= mul_a * mul_b;
                acc_reg  <= c_term;
            end
            DOT_MUL1: begin
                prod_reg <= mul_a * mul_b;
                acc_reg  <= acc_reg + prod_fl;
            end
            DOT_FIN: begin
                if (cmd.job == JOB_DET) begin
                    det_reg <= fin_sum;
                end
            end
            default: begin
            end
        endcase
    end

    // stack addressing
    always_comb begin
        if (cmd.pop_rd) begin
            slot = SLOT_W'(cnt_reg - CNT_W'(1));
        end else if (cnt_reg == CNT_W'(STACK_DEPTH)) begin
            slot = SLOT_W'(STACK_DEPTH - 1);
        end else begin
            slot = SLOT_W'(cnt_reg);
        end
        mem_addr = ADDR_W'(slot) * ADDR_W'(ENTRY_WORDS) + ADDR_W'(cmd.idx);
        push_word = '0;
        for (int k = 0; k < 6; k++) begin
            if (cmd.idx == IDX_W'(k)) begin
                push_word = fwd_reg[k];
            end
            if (cmd.idx == IDX_W'(k + 6)) begin
                push_word = inv_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            mem[mem_addr] <= push_word;
        end
        mem_rd_reg <= mem[mem_addr];
    end

    // divider operand select
    always_comb begin
        unique case (cmd.idx[1:0])
            2'd0: div_t = fwd_reg[0];
            2'd1: div_t = fwd_reg[1];
            2'd2: div_t = fwd_reg[3];
            2'd3: div_t = fwd_reg[4];
            default: div_t = fwd_reg[0];
        endcase
        div_tm  = div_t[WORD_W-1] ? WORD_W'(-div_t) : div_t;
        det_mag = det_reg[ACC_W-1] ? ACC_W'(-det_reg) : ACC_W'(det_reg);
        rem_sh  = {rem_reg, q_reg[NUM_W-1]};
        if (!div_neg_reg) begin
            q_sat = (q_reg > Q_POS_LIM) ? ACC_MAX[WORD_W-1:0] : q_reg[WORD_W-1:0];
        end else begin
            q_sat = (q_reg > Q_NEG_LIM) ? ACC_MIN[WORD_W-1:0]
                                        : WORD_W'(-q_reg[WORD_W-1:0]);
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
        end else if (div_busy_reg && div_cnt_reg == DIV_CNT_W'(1)) begin
            div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            q_reg       <= {div_tm, {FRAC_BITS{1'b0}}};
            rem_reg     <= '0;
            den_reg     <= det_mag;
            div_neg_reg <= div_t[WORD_W-1] ^ det_reg[ACC_W-1];
            div_cnt_reg <= DIV_CNT_W'(NUM_W);
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= ACC_W'(rem_sh - {1'b0, den_reg});
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[ACC_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // angle folding and cordic step
    always_comb begin
        zs = z_neg_reg ? -CORD_W'(zm_reg) : CORD_W'(zm_reg);
        z1 = zs;
        if (zs > Q30_PI) begin
            z1 = zs - Q30_TWO_PI;
        end else if (zs < -Q30_PI) begin
            z1 = zs + Q30_TWO_PI;
        end
        z2 = z1;
        flip_n = 1'b0;
        if (z1 > Q30_HALF_PI) begin
            z2 = z1 - Q30_PI;
            flip_n = 1'b1;
        end else if (z1 < -Q30_HALF_PI) begin
            z2 = z1 + Q30_PI;
            flip_n = 1'b1;
        end
        atan_v = CORD_W'(atan_q30(it_reg));
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        if (z_reg >= 0) begin
            nx = x_reg - ys;
            ny = y_reg + xs;
            nz = z_reg - atan_v;
        end else begin
            nx = x_reg + ys;
            ny = y_reg - xs;
            nz = z_reg + atan_v;
        end
        fx = flip_reg ? -nx : nx;
        fy = flip_reg ? -ny : ny;
        ang_mag = ang_reg[WORD_W-1] ? WORD_W'(-ang_reg) : ang_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_busy_reg <= 1'b0;
            rot_ph_reg   <= RP_RED;
        end else if (cmd.rot_start) begin
            rot_busy_reg <= 1'b1;
            rot_ph_reg   <= RP_RED;
        end else if (rot_busy_reg) begin
            unique case (rot_ph_reg)
                RP_RED: begin
                    if (mod_reg == RED_BASE) begin
                        rot_ph_reg <= RP_FOLD;
                    end
                end
                RP_FOLD: rot_ph_reg <= RP_ITER;
                RP_ITER: begin
                    if (it_reg == ATAN_IDX_W'(CORD_ITER - 1)) begin
                        rot_busy_reg <= 1'b0;
                    end
                end
                default: rot_ph_reg <= RP_RED;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rot_start) begin
            zm_reg    <= {ang_mag, {Q30_SHIFT{1'b0}}};
            z_neg_reg <= ang_reg[WORD_W-1];
            mod_reg   <= RED_TOP;
        end else if (rot_busy_reg) begin
            unique case (rot_ph_reg)
                RP_RED: begin
                    if (zm_reg >= mod_reg) begin
                        zm_reg <= zm_reg - mod_reg;
                    end
                    mod_reg <= mod_reg >> 1;
                end
                RP_FOLD: begin
                    z_reg    <= z2;
                    flip_reg <= flip_n;
                    x_reg    <= Q30_GAIN;
                    y_reg    <= '0;
                    it_reg   <= '0;
                end
                RP_ITER: begin
                    x_reg  <= nx;
                    y_reg  <= ny;
                    z_reg  <= nz;
                    it_reg <= it_reg + ATAN_IDX_W'(1);
                    cs_reg <= q30_round(fx);
                    sn_reg <= q30_round(fy);
                end
                default: begin
                end
            endcase
        end
    end

    // captured item, left matrix and scratch matrices
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= in_op;
            px_reg  <= in_x;
            py_reg  <= in_y;
            sc_reg  <= in_sc;
            ang_reg <= in_ang;
        end
        if (cmd.load_l) begin
            l_reg[0] <= Q_ONE; l_reg[1] <= '0; l_reg[2] <= '0;
            l_reg[3] <= '0;    l_reg[4] <= Q_ONE; l_reg[5] <= '0;
            unique case (op_reg)
                OP_TRANS: begin
                    l_reg[2] <= px_reg;
                    l_reg[5] <= py_reg;
                end
                OP_SCALE: begin
                    l_reg[0] <= sc_reg;
                    l_reg[4] <= sc_reg;
                end
                OP_ROT: begin
                    l_reg[0] <= cs_reg;
                    l_reg[1] <= -sn_reg;
                    l_reg[3] <= sn_reg;
                    l_reg[4] <= cs_reg;
                end
                default: begin
                end
            endcase
        end
        if (cmd.dot_ph == DOT_FIN) begin
            for (int k = 0; k < 6; k++) begin
                if (cmd.job == JOB_PRE && cmd.idx == IDX_W'(k)) begin
                    d_reg[k] <= fin_sat;
                end
            end
            if (cmd.job == JOB_OFF) begin
                if (cmd.idx == 4'd0) begin
                    v_reg[2] <= fin_sat;
                end else begin
                    v_reg[5] <= fin_sat;
                end
            end
        end
        if (cmd.div_wr) begin
            unique case (cmd.idx[1:0])
                2'd0: v_reg[0] <= q_sat;
                2'd1: v_reg[3] <= q_sat;
                2'd2: v_reg[1] <= q_sat;
                2'd3: v_reg[4] <= q_sat;
                default: v_reg[0] <= q_sat;
            endcase
        end
        if (cmd.capture) begin
            rx_reg <= '0;
            ry_reg <= '0;
        end else if (cmd.dot_ph == DOT_FIN && cmd.job == JOB_MAP) begin
            if (cmd.idx == 4'd0) begin
                rx_reg <= fin_sat;
            end else begin
                ry_reg <= fin_sat;
            end
        end
    end

    // current matrix pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) begin
                fwd_reg[k] <= (k == 0 || k == 4) ? Q_ONE : '0;
                inv_reg[k] <= (k == 0 || k == 4) ? Q_ONE : '0;
            end
            pop_wb_reg <= 1'b0;
        end else begin
            pop_wb_reg <= cmd.pop_rd;
            if (cmd.copy_d) begin
                fwd_reg <= d_reg;
            end
            if (cmd.copy_v) begin
                inv_reg <= v_reg;
            end
            if (pop_wb_reg) begin
                for (int k = 0; k < 6; k++) begin
                    if (pop_idx_reg == IDX_W'(k)) begin
                        fwd_reg[k] <= mem_rd_reg;
                    end
                    if (pop_idx_reg == IDX_W'(k + 6)) begin
                        inv_reg[k] <= mem_rd_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        pop_idx_reg <= cmd.idx;
    end

    // level and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            sing_reg <= 1'b0;
            ign_reg  <= 1'b0;
        end else begin
            if (cmd.cnt_inc && cnt_reg != CNT_W'(STACK_DEPTH)) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.set_sing) begin
                sing_reg <= 1'b1;
            end else if (cmd.capture) begin
                sing_reg <= 1'b0;
            end
            if (cmd.set_ign) begin
                ign_reg <= 1'b1;
            end else if (cmd.capture) begin
                ign_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_x_reg     <= rx_reg;
            out_y_reg     <= ry_reg;
            out_level_reg <= LEVEL_W'(cnt_reg);
            out_sing_reg  <= sing_reg;
            out_ign_reg   <= ign_reg;
        end
    end

    assign res_x     = out_x_reg;
    assign res_y     = out_y_reg;
    assign res_level = out_level_reg;
    assign res_sing  = out_sing_reg;
    assign res_ign   = out_ign_reg;

    assign sts.empty    = (cnt_reg == '0);
    assign sts.full     = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign sts.rot_busy = rot_busy_reg;
    assign sts.div_busy = div_busy_reg;
    assign sts.det_zero = (det_reg == '0);

endmodule

>>> rtl/core/atstk_ctrl.sv
module atstk_ctrl import atstk_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [OP_W-1:0] in_op,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  sts_t            sts,
    output cmd_t            cmd
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_PUSH  = 15'b000000000000010,
        ST_POP   = 15'b000000000000100,
        ST_POPW  = 15'b000000000001000,
        ST_ROT   = 15'b000000000010000,
        ST_LOADL = 15'b000000000100000,
        ST_PRE   = 15'b000000001000000,
        ST_COPYD = 15'b000000010000000,
        ST_DET   = 15'b000000100000000,
        ST_DIVS  = 15'b000001000000000,
        ST_DIVW  = 15'b000010000000000,
        ST_OFF   = 15'b000100000000000,
        ST_COPYV = 15'b001000000000000,
        ST_MAP   = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(ENTRY_WORDS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    dot_ph_t          ph_reg, ph_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // dot phase stepping shared by the product states
    function automatic dot_ph_t ph_step(input dot_ph_t p);
        dot_ph_t r;
        unique case (p)
            DOT_MUL0: r = DOT_MUL1;
            DOT_MUL1: r = DOT_FIN;
            default:  r = DOT_MUL0;
        endcase
        return r;
    endfunction

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ph_next        = ph_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.idx        = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                ph_next  = DOT_MUL0;
                if (accept) begin
                    cmd.capture = 1'b1;
                    priority case (in_op)
                        OP_PUSH: state_next = ST_PUSH;
                        OP_POP: begin
                            if (sts.empty) begin
                                cmd.set_ign = 1'b1;
                                state_next  = ST_DONE;
                            end else begin
                                state_next = ST_POP;
                            end
                        end
                        OP_TRANS, OP_SCALE: state_next = ST_LOADL;
                        OP_ROT: state_next = ST_ROT;
                        OP_W2S, OP_S2W: state_next = ST_MAP;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUSH: begin
                cmd.push_wr = 1'b1;
                idx_next    = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_WORD) begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_POP: begin
                cmd.pop_rd = 1'b1;
                idx_next   = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_WORD) begin
                    state_next = ST_POPW;
                end
            end
            ST_POPW: begin
                cmd.cnt_dec = 1'b1;
                state_next  = ST_DONE;
            end
            ST_ROT: begin
                // first cycle starts the unit, then wait for it
                if (idx_reg == '0) begin
                    cmd.rot_start = 1'b1;
                    idx_next      = IDX_W'(1);
                end else if (!sts.rot_busy) begin
                    idx_next   = '0;
                    state_next = ST_LOADL;
                end
            end
            ST_LOADL: begin
                cmd.load_l = 1'b1;
                idx_next   = '0;
                ph_next    = DOT_MUL0;
                state_next = ST_PRE;
            end
            ST_PRE, ST_DET, ST_OFF, ST_MAP: begin
                cmd.dot_ph = ph_reg;
                ph_next    = ph_step(ph_reg);
                priority case (state_reg)
                    ST_PRE:  cmd.job = JOB_PRE;
                    ST_DET:  cmd.job = JOB_DET;
                    ST_OFF:  cmd.job = JOB_OFF;
                    default: cmd.job = JOB_MAP;
                endcase
                if (ph_reg == DOT_FIN) begin
                    idx_next = idx_reg + IDX_W'(1);
                    priority if (state_reg == ST_PRE && idx_reg == IDX_W'(5)) begin
                        state_next = ST_COPYD;
                    end else if (state_reg == ST_DET) begin
                        idx_next   = '0;
                        state_next = ST_DIVS;
                    end else if (state_reg == ST_OFF && idx_reg == IDX_W'(1)) begin
                        state_next = ST_COPYV;
                    end else if (state_reg == ST_MAP && idx_reg == IDX_W'(1)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = state_reg;
                    end
                end
            end
            ST_COPYD: begin
                cmd.copy_d = 1'b1;
                idx_next   = '0;
                ph_next    = DOT_MUL0;
                state_next = ST_DET;
            end
            ST_DIVS: begin
                if (sts.det_zero) begin
                    cmd.set_sing = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (!sts.div_busy) begin
                    cmd.div_wr = 1'b1;
                    idx_next   = idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(3)) begin
                        idx_next   = '0;
                        ph_next    = DOT_MUL0;
                        state_next = ST_OFF;
                    end else begin
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_COPYV: begin
                cmd.copy_v = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            ph_reg        <= DOT_MUL0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
